// ===== rtl/skvt_pkg.sv =====
package skvt_pkg;

	// default sizes of the table
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 16;
	localparam int VALUE_BITS_DEF  = 32;

	// fixed widths of the result word and the register
	localparam int VALUE_OUT_W = 32;
	localparam int COUNT_OUT_W = 5;

	// request codes
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	// command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cmd_t;

endpackage

// ===== rtl/small_key_value_table.sv =====
// Small key/value table: up to MAX_ENTRIES unique pairs in order of insertion,
// held in a row of cells that each compare their key with the request at once.
// One request word is taken per clock cycle and its result word appears in the
// next cycle from an output register; the request channel stalls only while
// that register holds a word the far side has not taken. The match and value
// chains through all cells set the critical path. Lookup returns the held
// value or missing_value; insert appends a new key unless the key is present
// or the table is full; delete removes the key and moves later pairs down.
// Every result reports the count and the empty and full flags after the request.
module small_key_value_table import skvt_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [VALUE_OUT_W-1:0] cfg_data,
	// requests
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             req_type,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [VALUE_BITS-1:0]  value_in,
	// results
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic                   found,
	output logic [VALUE_OUT_W-1:0] value_out,
	output logic [1:0]             status,
	output logic [COUNT_OUT_W-1:0] entry_count,
	output logic                   is_empty,
	output logic                   is_full
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [VALUE_OUT_W-1:0] missing_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nxt;
	logic                   rsp_valid_q;
	logic                   found_q;
	logic [VALUE_OUT_W-1:0] value_q;
	status_t                status_q;
	logic [CNT_W-1:0]       rsp_count_q;

	logic                   acc;
	logic                   hit;
	logic                   full;
	cmd_t                   cmd;
	cmd_t                   cmd_gated;
	status_t                st;
	logic [VALUE_OUT_W-1:0] vout;

	logic                  hit_chain [0:MAX_ENTRIES];
	logic [VALUE_BITS-1:0] val_chain [0:MAX_ENTRIES];
	logic [KEY_BITS-1:0]   cell_key  [0:MAX_ENTRIES-1];
	logic [VALUE_BITS-1:0] cell_val  [0:MAX_ENTRIES-1];

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_q <= '0;
		end else if (cfg_valid) begin
			missing_q <= cfg_data;
		end
	end

	// handshake on the request side
	assign req_stall = rsp_valid_q & rsp_stall;
	assign acc       = req_valid & ~req_stall;

	// row of cells
	assign hit_chain[0] = 1'b0;
	assign val_chain[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0]   nbr_k;
		logic [VALUE_BITS-1:0] nbr_v;

		// the top cell has no upper neighbour
		if (i == MAX_ENTRIES - 1) begin : g_top
			assign nbr_k = '0;
			assign nbr_v = '0;
		end else begin : g_mid
			assign nbr_k = cell_key[i+1];
			assign nbr_v = cell_val[i+1];
		end

		skvt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.valid      (CNT_W'(i) < count_q),
			.tail       (CNT_W'(i) == count_q),
			.cmd        (cmd_gated),
			.key        (key),
			.value_in   (value_in),
			.nbr_key    (nbr_k),
			.nbr_value  (nbr_v),
			.hit_in     (hit_chain[i]),
			.val_in     (val_chain[i]),
			.hit_out    (hit_chain[i+1]),
			.val_out    (val_chain[i+1]),
			.key_held   (cell_key[i]),
			.value_held (cell_val[i])
		);
	end

	assign hit  = hit_chain[MAX_ENTRIES];
	assign full = (count_q == CNT_W'(MAX_ENTRIES));
	assign vout = hit ? VALUE_OUT_W'(val_chain[MAX_ENTRIES]) : missing_q;

	// decode the request
	always_comb begin
		cmd       = '0;
		st        = ST_DONE;
		count_nxt = count_q;
		case (req_type)
			REQ_INSERT: begin
				if (hit) begin
					st = ST_PRESENT;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					cmd.ins   = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			REQ_DELETE: begin
				if (!hit) begin
					st = ST_ABSENT;
				end else begin
					cmd.del   = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				st = ST_DONE;
			end
		endcase
	end

	assign cmd_gated = acc ? cmd : '0;

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (acc) begin
			found_q     <= hit;
			value_q     <= vout;
			status_q    <= st;
			rsp_count_q <= count_nxt;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign value_out   = value_q;
	assign status      = status_q;
	assign entry_count = COUNT_OUT_W'(rsp_count_q);
	assign is_empty    = (rsp_count_q == '0);
	assign is_full     = (rsp_count_q == CNT_W'(MAX_ENTRIES));

endmodule

// ===== rtl/skvt_cell.sv =====
module skvt_cell import skvt_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  valid,
	input  logic                  tail,
	input  cmd_t                  cmd,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value_in,
	input  logic [KEY_BITS-1:0]   nbr_key,
	input  logic [VALUE_BITS-1:0] nbr_value,
	input  logic                  hit_in,
	input  logic [VALUE_BITS-1:0] val_in,
	output logic                  hit_out,
	output logic [VALUE_BITS-1:0] val_out,
	output logic [KEY_BITS-1:0]   key_held,
	output logic [VALUE_BITS-1:0] value_held
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  hit;

	// compare against the request key
	assign hit = valid & (key_q == key);

	// match seen at this cell or below
	assign hit_out = hit_in | hit;

	// keys are unique, so at most one cell puts its value on the chain
	assign val_out = val_in | (hit ? val_q : '0);

	assign key_held   = key_q;
	assign value_held = val_q;

	// append at the tail, or take the upper neighbour's pair to close a gap
	always_ff @(posedge clk) begin
		if (cmd.ins && tail) begin
			key_q <= key;
			val_q <= value_in;
		end else if (cmd.del && hit_out) begin
			key_q <= nbr_key;
			val_q <= nbr_value;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import skvt_pkg::*;

	localparam int TBL_DEPTH  = MAX_ENTRIES_DEF;
	localparam int KEY_W      = KEY_BITS_DEF;
	localparam int VAL_W      = VALUE_BITS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int POOL_MAX   = 24;

	// request code with no operation of its own, taken as a lookup
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic                   found;
		logic [VALUE_OUT_W-1:0] value_out;
		status_t                status;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   is_empty;
		logic                   is_full;
	} table_rsp_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [VALUE_OUT_W-1:0] cfg_data  = '0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	logic [1:0]             req_type  = REQ_LOOKUP;
	logic [KEY_W-1:0]       key       = '0;
	logic [VAL_W-1:0]       value_in  = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	logic                   found;
	logic [VALUE_OUT_W-1:0] value_out;
	logic [1:0]             status;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic                   is_empty;
	logic                   is_full;

	// own copy of the table and its register
	logic [KEY_W-1:0]       shadow_keys [TBL_DEPTH];
	logic [VAL_W-1:0]       shadow_vals [TBL_DEPTH];
	int                     shadow_count = 0;
	logic [VALUE_OUT_W-1:0] shadow_missing = '0;

	table_rsp_t pending_rsp [$];

	int errors         = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int idle_cycles    = 0;
	int n_lookup       = 0;
	int n_insert       = 0;
	int n_delete       = 0;
	int n_unused       = 0;
	int n_hits         = 0;
	int n_full_reject  = 0;
	int n_cfg          = 0;

	logic [KEY_W-1:0] key_pool [POOL_MAX];
	int               pool_size = 1;

	small_key_value_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.key         (key),
		.value_in    (value_in),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.found       (found),
		.value_out   (value_out),
		.status      (status),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one request to the shadow table and work out its result word
	task automatic table_apply(input logic [1:0] rt, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, output table_rsp_t r);
		logic hit;
		int   pos;
		hit = 1'b0;
		pos = 0;
		for (int i = 0; i < shadow_count; i++) begin
			if (!hit && shadow_keys[i] == k) begin
				hit = 1'b1;
				pos = i;
			end
		end
		r.found     = hit;
		r.value_out = hit ? shadow_vals[pos] : shadow_missing;
		r.status    = ST_DONE;
		case (rt)
			REQ_INSERT: begin
				if (hit) begin
					r.status = ST_PRESENT;
				end else if (shadow_count >= TBL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_keys[shadow_count] = k;
					shadow_vals[shadow_count] = v;
					shadow_count++;
				end
			end
			REQ_DELETE: begin
				if (!hit) begin
					r.status = ST_ABSENT;
				end else begin
					// close the gap by moving later pairs down
					for (int i = pos; i + 1 < shadow_count; i++) begin
						shadow_keys[i] = shadow_keys[i + 1];
						shadow_vals[i] = shadow_vals[i + 1];
					end
					shadow_count--;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count[COUNT_OUT_W-1:0];
		r.is_empty    = (shadow_count == 0);
		r.is_full     = (shadow_count == TBL_DEPTH);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endtask

	// monitor: check result words, track register writes, predict requests
	always @(posedge clk) begin
		table_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: result word with none expected, expected nothing, actual %0h",
						$time, value_out);
					errors++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("found", want.found, found);
					check_field("value_out", want.value_out, value_out);
					check_field("status", want.status, status);
					check_field("entry_count", want.entry_count, entry_count);
					check_field("is_empty", want.is_empty, is_empty);
					check_field("is_full", want.is_full, is_full);
				end
			end
			if (cfg_valid && cfg_ready) begin
				shadow_missing = cfg_data;
				n_cfg++;
			end
			if (req_valid && !req_stall) begin
				table_apply(req_type, key, value_in, want);
				pending_rsp.push_back(want);
				case (req_type)
					REQ_LOOKUP: n_lookup++;
					REQ_INSERT: n_insert++;
					REQ_DELETE: n_delete++;
					default:    n_unused++;
				endcase
				if (want.found)
					n_hits++;
				if (want.status == ST_FULL)
					n_full_reject++;
			end
		end
	end

	// receiver stalls at random
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles where no word moves on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("FAIL small_key_value_table");
				$finish;
			end
		end
	end

	// send one request word, idling first at random
	task automatic send_request(input logic [1:0] rt, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= rt;
		key       <= k;
		value_in  <= v;
		do @(posedge clk); while (req_stall);
	endtask

	// stop sending and wait until every expected result word has come
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_missing_value(input logic [VALUE_OUT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// edges of the fields on a nearly empty table, missing value at reset
	task automatic test_edges();
		send_request(REQ_LOOKUP, 16'h0000, 32'h0000_0000);
		send_request(REQ_INSERT, 16'h0000, 32'h0000_0000);
		send_request(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 16'h0000, 32'h1234_5678);
		send_request(REQ_UNUSED, 16'hFFFF, 32'hA5A5_A5A5);
		send_request(REQ_DELETE, 16'h5A5A, 32'h0000_0000);
		send_request(REQ_DELETE, 16'h0000, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// fill to capacity, reject when full, delete from the middle
	task automatic test_fill();
		write_missing_value(32'hFFFF_FFFF);
		wait_drained();
		for (int i = 1; i < TBL_DEPTH; i++)
			send_request(REQ_INSERT, 16'(i * 16'h0111), $urandom);
		send_request(REQ_INSERT, 16'h7777, 32'hDEAD_BEEF);
		send_request(REQ_INSERT, 16'hFFFF, 32'h0000_0001);
		send_request(REQ_DELETE, 16'(7 * 16'h0111), 32'h0);
		send_request(REQ_LOOKUP, 16'(8 * 16'h0111), 32'h0);
		wait_drained();
	endtask

	// new pool of keys for one stretch of traffic, extremes now and then
	task automatic refill_pool();
		pool_size = $urandom_range(POOL_MAX, 4);
		for (int i = 0; i < POOL_MAX; i++) begin
			case ($urandom_range(9))
				0:       key_pool[i] = '0;
				1:       key_pool[i] = '1;
				default: key_pool[i] = KEY_W'($urandom);
			endcase
		end
	endtask

	task automatic random_request();
		int               pick;
		logic [1:0]       rt;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(99);
		if (pick < 20)
			rt = REQ_LOOKUP;
		else if (pick < 25)
			rt = REQ_UNUSED;
		else if (pick < 65)
			rt = REQ_INSERT;
		else
			rt = REQ_DELETE;
		if ($urandom_range(9) == 0)
			k = KEY_W'($urandom);
		else
			k = key_pool[$urandom_range(pool_size - 1)];
		send_request(rt, k, $urandom);
	endtask

	// random traffic under one idling profile, two register settings
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input logic [VALUE_OUT_W-1:0] miss_a, input logic [VALUE_OUT_W-1:0] miss_b);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int chunk = 0; chunk < 2; chunk++) begin
			wait_drained();
			write_missing_value(chunk == 0 ? miss_a : miss_b);
			refill_pool();
			repeat (275) random_request();
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 85;
		test_edges();
		test_fill();
		test_random_traffic(25, 85, 32'h0000_0000, $urandom);
		test_random_traffic(85, 25, $urandom, 32'hFFFF_FFFF);
		test_random_traffic(0, 0, $urandom, $urandom);

		repeat (5) @(posedge clk);
		$display("covered %0d lookups, %0d inserts, %0d deletes, %0d unused codes",
			n_lookup, n_insert, n_delete, n_unused);
		$display("with %0d hits, %0d full-table rejects and %0d register writes",
			n_hits, n_full_reject, n_cfg);
		if (errors == 0) begin
			$display("PASS small_key_value_table");
		end else begin
			$display("FAIL small_key_value_table");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/small_key_value_table.sv
tb/testbench.sv
